[hw/rtl/sscc_pkg.sv]
`default_nettype none

package sscc_pkg;

    // Controller states
    typedef enum logic [2:0] {
        ST_POWER_UP   = 3'd0,
        ST_LOCKED     = 3'd1,
        ST_FAULT      = 3'd2,
        ST_OVERRUN    = 3'd3,
        ST_FW_UPDATE  = 3'd4,
        ST_HARD_FAULT = 3'd5
    } t_ctrl_state;

    // Partner channel status
    typedef enum logic [1:0] {
        PARTNER_OFFLINE  = 2'd0,
        PARTNER_OK       = 2'd1,
        PARTNER_MISMATCH = 2'd2
    } t_partner;

    // Item kinds on the input tuser bit
    localparam logic REQ_TRANSITION = 1'b0;
    localparam logic REQ_CROSSCHECK = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAG_ENABLE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_LIMIT = 1'd1;

    localparam logic [7:0] MISMATCH_LIMIT_RST = 8'd3;
    localparam logic [7:0] MISMATCH_SAT       = 8'd255;

    // Persistent controller state
    typedef struct packed {
        t_ctrl_state ctrl;
        t_partner    partner;
        logic        pass;
        logic [7:0]  total;
        logic        byte_differs;
    } t_state;

    // One result item
    typedef struct packed {
        logic        wdc;
        logic        off;
        logic [7:0]  mismatches;
        logic        check_passing;
        logic [1:0]  partner_state;
        logic [2:0]  controller_state;
        logic        status;
    } t_result;

    // Allowed moves besides a self transition; bit t of entry s allows s -> t
    function automatic logic [5:0] allowed_mask(input t_ctrl_state from);
        logic [5:0] m;
        m = 6'b000000;
        unique case (from)
            ST_POWER_UP:   m = 6'b100010;
            ST_LOCKED:     m = 6'b111100;
            ST_FAULT:      m = 6'b100010;
            ST_OVERRUN:    m = 6'b100100;
            ST_FW_UPDATE:  m = 6'b100001;
            ST_HARD_FAULT: m = 6'b000000;
            default:       m = 6'b000000;
        endcase
        return m;
    endfunction

    function automatic logic transition_ok(input t_ctrl_state from, input logic [2:0] to);
        logic [5:0] m;
        logic       ok;
        m  = allowed_mask(from);
        ok = 1'b0;
        if (to <= 3'd5) begin
            ok = (to == from) || m[to];
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/sscc_step.sv]
`default_nettype none

module sscc_step (
    input  sscc_pkg::t_state  i_state,
    input  logic              i_diag_enable,
    input  logic [7:0]        i_mismatch_limit,
    input  logic              i_req_type,
    input  logic [2:0]        i_target_state,
    input  logic [7:0]        i_my_byte,
    input  logic [7:0]        i_partner_byte,
    input  logic              i_last_byte,
    output sscc_pkg::t_state  o_state,
    output sscc_pkg::t_result o_result,
    output logic              o_result_valid
);
    import sscc_pkg::*;

    logic       differs;
    logic [7:0] total_inc;
    logic       fault_ok;
    logic       req_ok;

    always_comb begin
        differs   = i_state.byte_differs | (i_my_byte != i_partner_byte);
        total_inc = (i_state.total == MISMATCH_SAT) ? i_state.total : i_state.total + 8'd1;
        fault_ok  = transition_ok(i_state.ctrl, 3'(ST_FAULT));
        req_ok    = transition_ok(i_state.ctrl, i_target_state);

        o_state        = i_state;
        o_result_valid = 1'b1;
        o_result       = '0;

        if (i_req_type == REQ_TRANSITION) begin
            o_result.status = ~req_ok;
            if (req_ok) begin
                o_state.ctrl = t_ctrl_state'(i_target_state);
                o_result.off = (i_target_state == 3'(ST_FAULT))
                            || (i_target_state == 3'(ST_HARD_FAULT))
                            || (i_target_state == 3'(ST_OVERRUN));
                o_result.wdc = (i_target_state == 3'(ST_LOCKED));
            end
        end else if (!i_last_byte) begin
            // Intermediate pair: fold into the running difference, no item out
            o_state.byte_differs = differs;
            o_result_valid       = 1'b0;
        end else begin
            o_state.byte_differs = 1'b0;
            if (i_diag_enable) begin
                if (!differs) begin
                    o_state.pass    = 1'b1;
                    o_state.partner = PARTNER_OK;
                    o_state.total   = '0;
                end else begin
                    o_state.pass  = 1'b0;
                    o_state.total = total_inc;
                    if (total_inc > i_mismatch_limit) begin
                        o_state.partner = PARTNER_MISMATCH;
                        if (fault_ok) begin
                            o_state.ctrl = ST_FAULT;
                            o_result.off = 1'b1;
                        end
                    end
                end
                o_result.status = differs || (o_state.partner == PARTNER_OFFLINE);
            end
        end

        o_result.controller_state = o_state.ctrl;
        o_result.partner_state    = o_state.partner;
        o_result.check_passing    = o_state.pass;
        o_result.mismatches       = o_state.total;
    end

endmodule

`default_nettype wire

[hw/rtl/safety_state_cross_check_core.sv]
`default_nettype none

// Safety state controller with dual-channel cross-check. Each input item is
// either a transition request (tuser = 0, target state in tdata) or one byte
// pair of a cross-check (tuser = 1, tlast marks the final pair). Requests and
// final pairs produce one output item; intermediate pairs produce none. The
// block takes one item per clock while the output is not stalled: an item is
// registered on entry, evaluated against the controller state in one
// combinational pass, and moves into the output register once that register
// is empty or being taken, and tvalid is driven from that register.
// The input register holds one item while the output is stalled, so the
// slave side drops ready only when both stages are full and the output is
// stalled. Configuration (diagnostic enable, mismatch limit) is written
// through a plain write port and must only change while the block is idle.
module safety_state_cross_check_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port
    input  logic                          i_cfg_wr_en,
    input  logic [sscc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_wdata,
    // Input stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [23:0]                   i_s_axis_tdata,  // target_state[2:0], my_byte[10:3],
                                                           // partner_byte[18:11], zero fill
    input  logic                          i_s_axis_tuser,  // req_type
    input  logic                          i_s_axis_tlast,  // last_byte
    // Output stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [23:0]                   o_m_axis_tdata   // status[0], controller_state[3:1],
                                                           // partner_state[5:4],
                                                           // check_passing[6], mismatches[14:7],
                                                           // outputs_off[15], watchdog_clear[16],
                                                           // zero fill
);
    import sscc_pkg::*;

    // Configuration registers
    logic       r_diag_enable;
    logic [7:0] r_mismatch_limit;

    // Controller state
    t_state r_state;
    t_state n_state;

    // Input stage
    logic       r_in_valid;
    logic       r_in_req_type;
    logic [2:0] r_in_target;
    logic [7:0] r_in_my_byte;
    logic [7:0] r_in_partner_byte;
    logic       r_in_last;

    // Output stage
    logic    r_out_valid;
    t_result r_out;
    t_result n_result;
    logic    n_result_valid;

    logic out_advance;
    logic in_accept;

    // Output register frees when empty or taken this cycle
    assign out_advance     = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || out_advance;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    sscc_step u_step (
        .i_state          (r_state),
        .i_diag_enable    (r_diag_enable),
        .i_mismatch_limit (r_mismatch_limit),
        .i_req_type       (r_in_req_type),
        .i_target_state   (r_in_target),
        .i_my_byte        (r_in_my_byte),
        .i_partner_byte   (r_in_partner_byte),
        .i_last_byte      (r_in_last),
        .o_state          (n_state),
        .o_result         (n_result),
        .o_result_valid   (n_result_valid)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diag_enable    <= 1'b1;
            r_mismatch_limit <= MISMATCH_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_DIAG_ENABLE:    r_diag_enable    <= i_cfg_wdata[0];
                CFG_MISMATCH_LIMIT: r_mismatch_limit <= i_cfg_wdata;
                default:            ;
            endcase
        end
    end

    // Pipeline control and state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{ctrl: ST_POWER_UP, partner: PARTNER_OFFLINE, pass: 1'b1,
                             total: 8'd0, byte_differs: 1'b0};
        end else begin
            // Commit the registered item when the output stage can take it
            if (out_advance) begin
                r_out_valid <= r_in_valid && n_result_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (out_advance) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_req_type     <= i_s_axis_tuser;
            r_in_target       <= i_s_axis_tdata[2:0];
            r_in_my_byte      <= i_s_axis_tdata[10:3];
            r_in_partner_byte <= i_s_axis_tdata[18:11];
            r_in_last         <= i_s_axis_tlast;
        end
        if (out_advance && r_in_valid) begin
            r_out <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out};

    // Hard fault is terminal
    a_hard_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.ctrl == ST_HARD_FAULT |=> r_state.ctrl == ST_HARD_FAULT)
        else $error("left hard fault state");

    // A mismatched partner implies a nonzero count
    a_mismatch_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.partner == PARTNER_MISMATCH |-> r_state.total != 8'd0)
        else $error("partner mismatch with zero count");

    // A failed check implies a nonzero count
    a_fail_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.pass |-> r_state.total != 8'd0)
        else $error("failing check with zero count");

    // De-energize and watchdog clear never in the same item
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.off && r_out.wdc))
        else $error("outputs_off and watchdog_clear together");

endmodule

`default_nettype wire

[verif/tb_top.sv]
`default_nettype none

module tb_top;
    import sscc_pkg::*;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #6 i_clk = ~i_clk;

    // Stimulus side of the block, all driven from time zero
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = CFG_DIAG_ENABLE;
    logic [7:0]           cfg_data  = 8'd0;
    logic                 s_valid   = 1'b0;
    logic [23:0]          s_data    = 24'd0;
    logic                 s_user    = REQ_TRANSITION;
    logic                 s_last    = 1'b0;
    logic                 m_ready   = 1'b0;
    logic                 s_ready;
    logic                 m_valid;
    logic [23:0]          m_data;

    safety_state_cross_check_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_we),
        .i_cfg_index     (cfg_idx),
        .i_cfg_wdata     (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // target_state, my_byte, partner_byte, zero fill
        .i_s_axis_tuser  (s_user),   // req_type
        .i_s_axis_tlast  (s_last),   // last_byte
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)    // status, controller_state, partner_state,
                                     // check_passing, mismatches, outputs_off,
                                     // watchdog_clear, zero fill
    );

    // One row of stimulus: either an input item or a register write.
    // A pinned row carries its expected result typed in by hand.
    typedef enum bit {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [7:0]           val;
        logic                 req;
        logic [2:0]           tgt;
        logic [7:0]           mine;
        logic [7:0]           theirs;
        logic                 lst;
        bit                   pinned;
        t_result              exp;
    } t_row;

    // Controller mirror: state and configuration as the block should hold them
    t_ctrl_state ctl_now;
    t_partner    partner_now;
    logic        pass_now;
    logic [7:0]  miss_run;
    logic        diff_pending;
    logic        diag_en;
    logic [7:0]  limit_now;

    t_result pending_results[$];
    t_row    table_q[$];
    int      err_count = 0;
    bit      idle_on   = 1'b1;
    int      stall_left = 0;
    t_result want;
    t_result got;

    // Legal moves besides staying put; hard fault is a dead end
    function automatic bit move_allowed(input t_ctrl_state from, input logic [2:0] to);
        if (to > ST_HARD_FAULT) return 1'b0;
        if (to == from) return 1'b1;
        case (from)
            ST_POWER_UP:  return (to == ST_LOCKED) || (to == ST_HARD_FAULT);
            ST_LOCKED:    return (to == ST_FAULT) || (to == ST_OVERRUN) ||
                                 (to == ST_FW_UPDATE) || (to == ST_HARD_FAULT);
            ST_FAULT:     return (to == ST_LOCKED) || (to == ST_HARD_FAULT);
            ST_OVERRUN:   return (to == ST_FAULT) || (to == ST_HARD_FAULT);
            ST_FW_UPDATE: return (to == ST_POWER_UP) || (to == ST_HARD_FAULT);
            default:      return 1'b0;
        endcase
    endfunction

    // Take a move if the table allows it and raise the entry flags
    task automatic try_move(input logic [2:0] to, inout bit off, inout bit wdc, output bit ok);
        ok = move_allowed(ctl_now, to);
        if (ok) begin
            ctl_now = t_ctrl_state'(to);
            if (to == ST_FAULT || to == ST_HARD_FAULT || to == ST_OVERRUN) off = 1'b1;
            if (to == ST_LOCKED) wdc = 1'b1;
        end
    endtask

    // Advance the mirror by one accepted item and build the result it causes
    task automatic step_controller(input t_row r, output bit produces, output t_result res_o);
        bit   diff;
        bit   ok;
        bit   off;
        bit   wdc;
        logic st;
        off      = 1'b0;
        wdc      = 1'b0;
        st       = 1'b0;
        produces = 1'b1;
        res_o    = '0;
        if (r.req == REQ_TRANSITION) begin
            try_move(r.tgt, off, wdc, ok);
            st = !ok;
        end else begin
            diff = diff_pending | (r.mine != r.theirs);
            if (!r.lst) begin
                // intermediate pair: remember a difference, no result
                diff_pending = diff;
                produces     = 1'b0;
            end else begin
                diff_pending = 1'b0;
                if (diag_en) begin
                    if (!diff) begin
                        pass_now    = 1'b1;
                        partner_now = PARTNER_OK;
                        miss_run    = 8'd0;
                    end else begin
                        pass_now = 1'b0;
                        if (miss_run != MISMATCH_SAT) miss_run = miss_run + 8'd1;
                        if (miss_run > limit_now) begin
                            partner_now = PARTNER_MISMATCH;
                            try_move(ST_FAULT, off, wdc, ok);
                        end
                    end
                    st = diff || (partner_now == PARTNER_OFFLINE);
                end
            end
        end
        res_o.status           = st;
        res_o.controller_state = ctl_now;
        res_o.partner_state    = partner_now;
        res_o.check_passing    = pass_now;
        res_o.mismatches       = miss_run;
        res_o.off              = off;
        res_o.wdc              = wdc;
    endtask

    function automatic t_row mk_item(input logic req, input logic [2:0] tgt,
                                     input logic [7:0] a, input logic [7:0] b,
                                     input logic lst);
        t_row r;
        r        = '0;
        r.kind   = ROW_ITEM;
        r.req    = req;
        r.tgt    = tgt;
        r.mine   = a;
        r.theirs = b;
        r.lst    = lst;
        return r;
    endfunction

    function automatic t_row mk_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        t_row r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    function automatic t_row pin(input t_row r, input logic st, input t_ctrl_state c,
                                 input t_partner p, input logic ps, input logic [7:0] m,
                                 input logic off, input logic wdc);
        r.pinned                   = 1'b1;
        r.exp.status               = st;
        r.exp.controller_state     = c;
        r.exp.partner_state        = p;
        r.exp.check_passing        = ps;
        r.exp.mismatches           = m;
        r.exp.off                  = off;
        r.exp.wdc                  = wdc;
        return r;
    endfunction

    // Offer one item, hold it until taken, then log what it should produce
    task automatic send_item(input t_row r);
        bit      produces;
        t_result res_o;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {5'd0, r.theirs, r.mine, r.tgt};
        s_user  <= r.req;
        s_last  <= r.lst;
        do @(posedge i_clk); while (s_ready !== 1'b1);
        step_controller(r, produces, res_o);
        if (produces) pending_results.push_back(r.pinned ? r.exp : res_o);
    endtask

    // Write a register only once the block has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // an intermediate pair may still be in flight without a result
        repeat (4) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        if (idx == CFG_DIAG_ENABLE) diag_en = val[0];
        else limit_now = val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_rows();
        foreach (table_q[i]) begin
            if (table_q[i].kind == ROW_CFG) write_reg(table_q[i].idx, table_q[i].val);
            else send_item(table_q[i]);
        end
        table_q.delete();
    endtask

    // Mostly valid targets; hard fault is kept for the end since it never leaves
    function automatic logic [2:0] pick_target();
        if ($urandom_range(0, 7) == 0) return 3'($urandom_range(6, 7));
        return 3'($urandom_range(0, 4));
    endfunction

    // Random traffic: transition requests mixed with well-formed comparisons
    // of 1..max_len pairs, one pair differing in a share of them, plus noise
    task automatic run_random(input int n, input int trans_pct, input int miss_pct,
                              input int max_len);
        int         sent;
        int         len;
        int         bad_at;
        int         k;
        bit         noisy;
        bit         lst;
        logic [7:0] a;
        logic [7:0] b;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 99) < trans_pct) begin
                send_item(mk_item(REQ_TRANSITION, pick_target(), 8'($urandom),
                                  8'($urandom), 1'($urandom)));
                sent++;
            end else begin
                len    = $urandom_range(1, max_len);
                noisy  = ($urandom_range(0, 9) == 0);
                bad_at = ($urandom_range(0, 99) < miss_pct) ? $urandom_range(0, len - 1) : -1;
                for (k = 0; k < len; k++) begin
                    a = 8'($urandom);
                    b = a;
                    if (noisy) begin
                        b   = 8'($urandom);
                        lst = 1'($urandom);
                    end else begin
                        if (k == bad_at) b = a ^ 8'($urandom_range(1, 255));
                        lst = (k == len - 1);
                    end
                    send_item(mk_item(REQ_CROSSCHECK, 3'($urandom), a, b, lst));
                    sent++;
                end
            end
        end
    endtask

    // Receiver: stall in random bursts, always ready in the closing part
    always @(posedge i_clk) begin
        if (!idle_on) begin
            stall_left <= 0;
            m_ready    <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 17) - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [7:0] e, input logic [7:0] g);
        if (e !== g) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, e, g);
            err_count++;
        end
    endtask

    // Compare every accepted result item with the oldest expectation
    always @(posedge i_clk) begin
        if (m_valid === 1'b1 && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result item: expected none, got %h", $time, m_data);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                got  = t_result'(m_data[16:0]);
                check_field("status", 8'(want.status), 8'(got.status));
                check_field("controller_state", 8'(want.controller_state),
                            8'(got.controller_state));
                check_field("partner_state", 8'(want.partner_state), 8'(got.partner_state));
                check_field("check_passing", 8'(want.check_passing), 8'(got.check_passing));
                check_field("mismatches", want.mismatches, got.mismatches);
                check_field("outputs_off", 8'(want.off), 8'(got.off));
                check_field("watchdog_clear", 8'(want.wdc), 8'(got.wdc));
                check_field("zero fill", 8'd0, {1'b0, m_data[23:17]});
            end
        end
    end

    // Hard stop in case the block hangs
    initial begin
        #(12 * 200000);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        ctl_now      = ST_POWER_UP;
        partner_now  = PARTNER_OFFLINE;
        pass_now     = 1'b1;
        miss_run     = 8'd0;
        diff_pending = 1'b0;
        diag_en      = 1'b1;
        limit_now    = MISMATCH_LIMIT_RST;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, starting from the reset state
        table_q.push_back(pin(mk_item(REQ_TRANSITION, 3'd6, 8'hFF, 8'h00, 1'b1),
                              1'b1, ST_POWER_UP, PARTNER_OFFLINE, 1'b1, 8'd0, 1'b0, 1'b0));
        table_q.push_back(pin(mk_item(REQ_TRANSITION, 3'd7, 8'h00, 8'hFF, 1'b0),
                              1'b1, ST_POWER_UP, PARTNER_OFFLINE, 1'b1, 8'd0, 1'b0, 1'b0));
        table_q.push_back(pin(mk_item(REQ_TRANSITION, ST_POWER_UP, 8'h00, 8'h00, 1'b0),
                              1'b0, ST_POWER_UP, PARTNER_OFFLINE, 1'b1, 8'd0, 1'b0, 1'b0));
        table_q.push_back(pin(mk_item(REQ_TRANSITION, ST_FAULT, 8'hFF, 8'hFF, 1'b1),
                              1'b1, ST_POWER_UP, PARTNER_OFFLINE, 1'b1, 8'd0, 1'b0, 1'b0));
        // mismatch while the partner is still offline
        table_q.push_back(pin(mk_item(REQ_CROSSCHECK, 3'd0, 8'h00, 8'hFF, 1'b1),
                              1'b1, ST_POWER_UP, PARTNER_OFFLINE, 1'b0, 8'd1, 1'b0, 1'b0));
        table_q.push_back(pin(mk_item(REQ_TRANSITION, ST_LOCKED, 8'h00, 8'h00, 1'b0),
                              1'b0, ST_LOCKED, PARTNER_OFFLINE, 1'b0, 8'd1, 1'b0, 1'b1));
        // staying in locked still clears the watchdog
        table_q.push_back(pin(mk_item(REQ_TRANSITION, ST_LOCKED, 8'h00, 8'h00, 1'b0),
                              1'b0, ST_LOCKED, PARTNER_OFFLINE, 1'b0, 8'd1, 1'b0, 1'b1));
        table_q.push_back(mk_item(REQ_CROSSCHECK, 3'd7, 8'hFF, 8'hFF, 1'b0));
        table_q.push_back(pin(mk_item(REQ_CROSSCHECK, 3'd7, 8'hFF, 8'hFF, 1'b1),
                              1'b0, ST_LOCKED, PARTNER_OK, 1'b1, 8'd0, 1'b0, 1'b0));
        // an early differing pair spoils a matching final pair
        table_q.push_back(mk_item(REQ_CROSSCHECK, 3'd5, 8'hAA, 8'h55, 1'b0));
        table_q.push_back(mk_item(REQ_CROSSCHECK, 3'd2, 8'h12, 8'h12, 1'b1));
        table_q.push_back(mk_item(REQ_CROSSCHECK, 3'd0, 8'h01, 8'h80, 1'b1));
        table_q.push_back(mk_item(REQ_CROSSCHECK, 3'd0, 8'h80, 8'h00, 1'b1));
        // count passes the limit: partner mismatch and fault entry
        table_q.push_back(pin(mk_item(REQ_CROSSCHECK, 3'd0, 8'hFE, 8'h7F, 1'b1),
                              1'b1, ST_FAULT, PARTNER_MISMATCH, 1'b0, 8'd4, 1'b1, 1'b0));
        table_q.push_back(mk_item(REQ_CROSSCHECK, 3'd0, 8'h00, 8'h01, 1'b1));
        table_q.push_back(mk_item(REQ_TRANSITION, ST_LOCKED, 8'h5A, 8'hA5, 1'b0));
        table_q.push_back(mk_item(REQ_TRANSITION, ST_OVERRUN, 8'h00, 8'h00, 1'b0));
        table_q.push_back(mk_item(REQ_TRANSITION, ST_FAULT, 8'h00, 8'h00, 1'b0));
        table_q.push_back(mk_item(REQ_TRANSITION, ST_LOCKED, 8'h00, 8'h00, 1'b0));
        table_q.push_back(mk_item(REQ_TRANSITION, ST_FW_UPDATE, 8'h00, 8'h00, 1'b0));
        table_q.push_back(mk_item(REQ_TRANSITION, ST_POWER_UP, 8'h00, 8'h00, 1'b0));
        // diagnostic off: final pair passes without touching the state
        table_q.push_back(mk_cfg(CFG_DIAG_ENABLE, 8'd0));
        table_q.push_back(mk_item(REQ_CROSSCHECK, 3'd0, 8'h00, 8'h01, 1'b0));
        table_q.push_back(mk_item(REQ_CROSSCHECK, 3'd0, 8'h33, 8'h33, 1'b1));
        table_q.push_back(mk_cfg(CFG_DIAG_ENABLE, 8'd1));
        table_q.push_back(mk_item(REQ_CROSSCHECK, 3'd0, 8'h44, 8'h44, 1'b1));
        // limit zero: first mismatch asks for fault, rejected from power up
        table_q.push_back(mk_cfg(CFG_MISMATCH_LIMIT, 8'd0));
        table_q.push_back(mk_item(REQ_CROSSCHECK, 3'd0, 8'h10, 8'h01, 1'b1));
        run_rows();

        // Random phases over several settings
        write_reg(CFG_MISMATCH_LIMIT, MISMATCH_LIMIT_RST);
        run_random(50, 30, 50, 4);

        write_reg(CFG_DIAG_ENABLE, 8'd0);
        write_reg(CFG_MISMATCH_LIMIT, 8'($urandom));
        run_random(30, 30, 50, 4);

        write_reg(CFG_DIAG_ENABLE, 8'd1);
        write_reg(CFG_MISMATCH_LIMIT, 8'd0);
        run_random(40, 30, 40, 4);

        // limit 255: drive the count into saturation, no fault may follow
        write_reg(CFG_MISMATCH_LIMIT, MISMATCH_SAT);
        run_random(300, 3, 100, 1);

        // closing part runs without idling on either side
        write_reg(CFG_MISMATCH_LIMIT, 8'($urandom_range(1, 254)));
        idle_on = 1'b0;
        run_random(50, 30, 60, 3);

        // Hard fault last: it locks the controller for good
        table_q.push_back(mk_item(REQ_TRANSITION, ST_HARD_FAULT, 8'h00, 8'h00, 1'b0));
        table_q.push_back(mk_item(REQ_TRANSITION, ST_POWER_UP, 8'h00, 8'h00, 1'b0));
        table_q.push_back(mk_item(REQ_TRANSITION, 3'd6, 8'h00, 8'h00, 1'b0));
        table_q.push_back(mk_item(REQ_TRANSITION, ST_HARD_FAULT, 8'h00, 8'h00, 1'b1));
        table_q.push_back(mk_item(REQ_CROSSCHECK, 3'd0, 8'h00, 8'hFF, 1'b1));
        table_q.push_back(mk_item(REQ_CROSSCHECK, 3'd0, 8'h77, 8'h77, 1'b1));
        run_rows();

        // Drain, then give stray items a few cycles to show up
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
hw/rtl/sscc_pkg.sv
hw/rtl/sscc_step.sv
hw/rtl/safety_state_cross_check_core.sv
verif/tb_top.sv
